// File: src/fdh_pkg.sv
package fdh_pkg;

  localparam int P_W   = 19;
  localparam int CFG_W = 12;
  localparam int DRV_W = 8;
  localparam int IDX_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // 1 mbar in sample units (1/16 mbar)
  localparam int ONE_MBAR = 16;
  localparam logic [DRV_W-1:0] FULL_DRIVE = 8'd255;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [IDX_W-1:0] REG_START    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MARGIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_BAND     = 3'd3;
  localparam logic [IDX_W-1:0] REG_SINK_DET = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRIM     = 3'd5;

  localparam logic [P_W-1:0]   TARGET_RST   = 19'd16880;
  localparam logic [P_W-1:0]   START_RST    = 19'd16368;
  localparam logic [CFG_W-1:0] MARGIN_RST   = 12'd16;
  localparam logic [CFG_W-1:0] BAND_RST     = 12'd80;
  localparam logic [CFG_W-1:0] SINK_DET_RST = 12'd32;
  localparam logic [DRV_W-1:0] TRIM_RST     = 8'd100;

  typedef enum logic [2:0] {
    ACT_IDLE     = 3'd0,
    ACT_SINKING  = 3'd1,
    ACT_RISING   = 3'd2,
    ACT_FLOATING = 3'd3,
    ACT_STOPPING = 3'd4
  } action_t;

  typedef struct packed {
    logic [P_W-1:0]   target;
    logic [P_W-1:0]   start;
    logic [CFG_W-1:0] margin;
    logic [CFG_W-1:0] band;
    logic [CFG_W-1:0] sink_detect;
    logic [DRV_W-1:0] trim;
  } cfg_t;

  // packed from the top: last member sits in the lowest bits
  typedef struct packed {
    logic           tick;
    logic           pull_lvl;
    logic           push_lvl;
    logic           auto_sel;
    logic [P_W-1:0] pressure;
  } item_t;

  typedef struct packed {
    logic             auto_active;
    action_t          action;
    logic [DRV_W-1:0] drive_rise;
    logic [DRV_W-1:0] drive_sink;
  } result_t;

endpackage

// File: src/fdh_cfg_regs.sv
module fdh_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [fdh_pkg::IDX_W-1:0]    wr_index,
  input  logic [fdh_pkg::P_W-1:0]      wr_data,
  output fdh_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target      <= fdh_pkg::TARGET_RST;
      cfg.start       <= fdh_pkg::START_RST;
      cfg.margin      <= fdh_pkg::MARGIN_RST;
      cfg.band        <= fdh_pkg::BAND_RST;
      cfg.sink_detect <= fdh_pkg::SINK_DET_RST;
      cfg.trim        <= fdh_pkg::TRIM_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        fdh_pkg::REG_TARGET:   cfg.target      <= wr_data;
        fdh_pkg::REG_START:    cfg.start       <= wr_data;
        fdh_pkg::REG_MARGIN:   cfg.margin      <= wr_data[fdh_pkg::CFG_W-1:0];
        fdh_pkg::REG_BAND:     cfg.band        <= wr_data[fdh_pkg::CFG_W-1:0];
        fdh_pkg::REG_SINK_DET: cfg.sink_detect <= wr_data[fdh_pkg::CFG_W-1:0];
        fdh_pkg::REG_TRIM:     cfg.trim        <= wr_data[fdh_pkg::DRV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/fdh_ctrl.sv
module fdh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  fdh_pkg::item_t   item,
  input  fdh_pkg::cfg_t    cfg,
  output fdh_pkg::result_t result
);

  logic                         auto_latched, auto_latched_next;
  logic                         descent_done, descent_done_next;
  logic [fdh_pkg::P_W-1:0]      prior_pressure, prior_pressure_next;
  logic [fdh_pkg::P_W-1:0]      floor_pressure, floor_pressure_next;
  logic [fdh_pkg::P_W-1:0]      peak_error, peak_error_next;
  logic [fdh_pkg::P_W-1:0]      valley_error, valley_error_next;
  logic [fdh_pkg::DRV_W-1:0]    held_sink_drive, held_sink_drive_next;
  logic [fdh_pkg::DRV_W-1:0]    held_rise_drive, held_rise_drive_next;
  fdh_pkg::action_t             action;

  logic [fdh_pkg::P_W-1:0]      p;
  logic [fdh_pkg::P_W-1:0]      prior_eff;
  logic [fdh_pkg::P_W:0]        sink_limit;
  logic [fdh_pkg::P_W-1:0]      mag;
  logic                         near;
  logic [fdh_pkg::CFG_W:0]      slack;
  logic [fdh_pkg::CFG_W:0]      gap;
  logic [fdh_pkg::P_W-1:0]      peak_max;
  logic                         peak_ok;
  logic [fdh_pkg::P_W:0]        peak_bump;
  logic [fdh_pkg::P_W-1:0]      peak_sat;
  logic [fdh_pkg::P_W-1:0]      valley_min;
  logic                         valley_ok;
  logic [fdh_pkg::P_W-1:0]      valley_drop;
  logic [fdh_pkg::P_W-1:0]      slack_ext;
  logic [fdh_pkg::P_W-1:0]      gap_ext;

  assign p = item.pressure;
  // tick latches the sample before any decision in the same step
  assign prior_eff  = item.tick ? p : prior_pressure;
  assign sink_limit = {1'b0, prior_eff} + {{(fdh_pkg::P_W-fdh_pkg::CFG_W+1){1'b0}}, cfg.sink_detect};

  assign mag  = (p >= cfg.target) ? (p - cfg.target) : (cfg.target - p);
  assign near = mag < {{(fdh_pkg::P_W-fdh_pkg::CFG_W){1'b0}}, cfg.band};

  assign slack     = {1'b0, cfg.margin} + (fdh_pkg::CFG_W+1)'(fdh_pkg::ONE_MBAR);
  assign gap       = {1'b0, cfg.margin} + (fdh_pkg::CFG_W+1)'(3 * fdh_pkg::ONE_MBAR);
  assign slack_ext = {{(fdh_pkg::P_W-fdh_pkg::CFG_W-1){1'b0}}, slack};
  assign gap_ext   = {{(fdh_pkg::P_W-fdh_pkg::CFG_W-1){1'b0}}, gap};

  // deeper side: peak never below the sample here
  assign peak_max  = (peak_error < p) ? p : peak_error;
  assign peak_ok   = (peak_max - p) <= slack_ext;
  assign peak_bump = {1'b0, p} + {1'b0, gap_ext};
  assign peak_sat  = peak_bump[fdh_pkg::P_W] ? {fdh_pkg::P_W{1'b1}} : peak_bump[fdh_pkg::P_W-1:0];

  // shallower side: a sample below the valley also counts as within slack
  assign valley_min  = (valley_error > p && p < floor_pressure) ? p : valley_error;
  assign valley_ok   = (p < valley_min) || ((p - valley_min) <= slack_ext);
  assign valley_drop = (p < gap_ext) ? '0 : (p - gap_ext);

  always_comb begin
    auto_latched_next    = auto_latched;
    descent_done_next    = descent_done;
    prior_pressure_next  = prior_eff;
    floor_pressure_next  = floor_pressure;
    peak_error_next      = peak_error;
    valley_error_next    = valley_error;
    held_sink_drive_next = held_sink_drive;
    held_rise_drive_next = held_rise_drive;
    action               = fdh_pkg::ACT_IDLE;

    if (!auto_latched) begin
      if (item.auto_sel) begin
        auto_latched_next = 1'b1;
      end else if (!item.pull_lvl && item.push_lvl) begin
        held_sink_drive_next = fdh_pkg::FULL_DRIVE;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_SINKING;
      end else if (item.pull_lvl && !item.push_lvl) begin
        held_sink_drive_next = '0;
        held_rise_drive_next = fdh_pkg::FULL_DRIVE;
        action               = fdh_pkg::ACT_RISING;
      end else begin
        held_sink_drive_next = '0;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_STOPPING;
      end
    end else if (p < cfg.start) begin
      held_sink_drive_next = '0;
      held_rise_drive_next = '0;
    end else if (!descent_done) begin
      floor_pressure_next = p;
      if ({1'b0, p} > sink_limit) begin
        descent_done_next    = 1'b1;
        held_sink_drive_next = '0;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_STOPPING;
      end else begin
        held_sink_drive_next = fdh_pkg::FULL_DRIVE;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_SINKING;
      end
    end else if (near) begin
      held_sink_drive_next = '0;
      held_rise_drive_next = '0;
      action               = fdh_pkg::ACT_STOPPING;
    end else if (p > cfg.target) begin
      valley_error_next = cfg.target;
      if (peak_ok) begin
        peak_error_next      = peak_max;
        held_sink_drive_next = '0;
        held_rise_drive_next = cfg.trim;
        action               = fdh_pkg::ACT_FLOATING;
      end else begin
        peak_error_next      = peak_sat;
        held_sink_drive_next = '0;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_STOPPING;
      end
    end else begin
      peak_error_next = cfg.target;
      if (valley_ok) begin
        valley_error_next    = valley_min;
        held_sink_drive_next = cfg.trim;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_SINKING;
      end else begin
        valley_error_next    = valley_drop;
        held_sink_drive_next = '0;
        held_rise_drive_next = '0;
        action               = fdh_pkg::ACT_STOPPING;
      end
    end
  end

  always_comb begin
    result.auto_active = auto_latched_next;
    result.action      = action;
    result.drive_rise  = held_rise_drive_next;
    result.drive_sink  = held_sink_drive_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_latched    <= 1'b0;
      descent_done    <= 1'b0;
      prior_pressure  <= '0;
      floor_pressure  <= '0;
      peak_error      <= fdh_pkg::TARGET_RST;
      valley_error    <= fdh_pkg::TARGET_RST;
      held_sink_drive <= '0;
      held_rise_drive <= '0;
    end else if (advance) begin
      auto_latched    <= auto_latched_next;
      descent_done    <= descent_done_next;
      prior_pressure  <= prior_pressure_next;
      floor_pressure  <= floor_pressure_next;
      peak_error      <= peak_error_next;
      valley_error    <= valley_error_next;
      held_sink_drive <= held_sink_drive_next;
      held_rise_drive <= held_rise_drive_next;
    end
  end

endmodule

// File: src/float_depth_hold_controller_core.sv
// Channel  | Direction | Handshake         | Payload
// s_       | in        | s_tvalid/s_tready | s_tdata: one sample and switch levels
// m_       | out       | m_tvalid/m_tready | m_tdata: drive levels, action, mode
// cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data: register write
//
// One request in per cycle while the output is not stalled, one result per
// request. A request waits in the input register; the controller state update
// sits between it and the output register, which loads the result when empty
// or taken. Reset clears the valid flags, controller state and settings to
// defaults. A stalled output holds its result; the input register takes a new
// request whenever it is empty or hands its request on that cycle.
module float_depth_hold_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [18:0] pressure, [19] auto_sel, [20] push_lvl, [21] pull_lvl,
  // [22] tick, [23] zero
  input  logic [fdh_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] drive_sink, [15:8] drive_rise, [18:16] action, [19] auto_active,
  // [23:20] zero
  output logic [fdh_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdh_pkg::IDX_W-1:0]           cfg_index,
  input  logic [fdh_pkg::P_W-1:0]             cfg_data
);

  fdh_pkg::cfg_t    cfg;
  fdh_pkg::item_t   in_item;
  fdh_pkg::result_t step_result;
  fdh_pkg::result_t out_result;
  logic             in_valid;
  logic             out_valid;
  logic             advance;

  assign cfg_ready = 1'b1;

  fdh_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[$bits(fdh_pkg::item_t)-1:0];
    end
  end

  fdh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(fdh_pkg::OUT_TDATA_W-$bits(fdh_pkg::result_t)){1'b0}}, out_result};

endmodule

// File: src/fdh_checker.sv
module fdh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fdh_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [fdh_pkg::DRV_W-1:0] drv_sink;
  logic [fdh_pkg::DRV_W-1:0] drv_rise;
  logic [2:0]                act;
  logic                      auto_on;

  assign drv_sink = m_tdata[7:0];
  assign drv_rise = m_tdata[15:8];
  assign act      = m_tdata[18:16];
  assign auto_on  = m_tdata[19];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && act == fdh_pkg::ACT_STOPPING |-> drv_sink == '0 && drv_rise == '0)
    else $error("stopping with motor driven");

  a_rise_manual: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && act == fdh_pkg::ACT_RISING
      |-> !auto_on && drv_sink == '0 && drv_rise == fdh_pkg::FULL_DRIVE)
    else $error("rising outside manual full drive");

  a_float_auto: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && act == fdh_pkg::ACT_FLOATING |-> auto_on && drv_sink == '0)
    else $error("floating outside auto mode");

endmodule

bind float_depth_hold_controller_core fdh_checker u_fdh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
